[design/dtt_pkg.sv]
`default_nettype none

package dtt_pkg;

    // Query position counter width; the count saturates at its top value.
    localparam int QW = 7;
    localparam logic [QW-1:0] QPOS_MAX = 7'd127;

    localparam logic [7:0] SEMICOLON = 8'h3B;
    localparam logic [7:0] NUL_BYTE  = 8'h00;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ONE,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[design/dtt_if.sv]
`default_nettype none

interface dtt_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_byte;

    modport source (output valid, output op, output char_byte, input ready);
    modport sink   (input valid, input op, input char_byte, output ready);
endinterface

interface dtt_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [3:0] tag_index;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output found, output tag_index, output value_byte,
                     output byte_valid, output last, input ready);
    modport sink   (input valid, input found, input tag_index, input value_byte,
                     input byte_valid, input last, output ready);
endinterface

`default_nettype wire

[design/dtt_tag_ram.sv]
`default_nettype none

// Tag byte store, banked by byte position: one row per position, one byte
// lane per tag. Byte-lane write, whole-row registered read.
module dtt_tag_ram #(
    parameter int LANES = 16,
    parameter int ROWS  = 64,
    parameter int AW    = 6,
    parameter int LW    = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [LW-1:0]          i_wlane,
    input  wire logic [7:0]             i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [LANES-1:0][7:0]  o_rrow
);

    logic [LANES-1:0][7:0] r_mem [ROWS];
    logic [LANES-1:0][7:0] r_rrow;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wlane] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rrow <= r_mem[i_raddr];
        end
    end

    assign o_rrow = r_rrow;

endmodule

`default_nettype wire

[design/dtt_loader.sv]
`default_nettype none

// Load parser: splits the identification string into tags, drives the
// byte-lane write of the tag store and keeps the tag lengths.
module dtt_loader #(
    parameter int TAG_COUNT = 16,
    parameter int TAG_BYTES = 64,
    parameter int PW        = 6,
    parameter int IW        = 4,
    parameter int FTW       = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [7:0]                    i_byte,
    output logic                               o_we,
    output logic      [PW-1:0]                 o_waddr,
    output logic      [IW-1:0]                 o_wlane,
    output logic      [7:0]                    o_wdata,
    output logic      [TAG_COUNT-1:0][PW-1:0]  o_tag_len
);

    logic [FTW-1:0]               r_fill_tag, n_fill_tag;
    logic [PW-1:0]                r_fill_pos, n_fill_pos;
    logic                         r_swallow, n_swallow;
    logic                         r_active, n_active;
    logic [TAG_COUNT-1:0][PW-1:0] r_tag_len, n_tag_len;

    logic [FTW-1:0] w_ft;
    logic [PW-1:0]  w_fp;
    logic [PW-1:0]  w_fp_inc;
    logic           w_sw;
    logic           w_clear;
    logic           w_len_we;
    logic [PW-1:0]  w_len_val;

    always_comb begin
        // A fresh load restarts from tag 0 with all lengths cleared.
        w_clear  = i_load && !r_active;
        w_ft     = r_active ? r_fill_tag : '0;
        w_fp     = r_active ? r_fill_pos : '0;
        w_sw     = r_active ? r_swallow  : 1'b0;
        w_fp_inc = w_fp + PW'(1);

        n_fill_tag = r_fill_tag;
        n_fill_pos = r_fill_pos;
        n_swallow  = r_swallow;
        n_active   = r_active;
        w_len_we   = 1'b0;
        w_len_val  = w_fp;
        o_we       = 1'b0;

        if (i_load) begin
            n_fill_tag = w_ft;
            n_fill_pos = w_fp;
            n_swallow  = w_sw;
            if (i_byte == dtt_pkg::NUL_BYTE) begin
                n_active = 1'b0;
            end else begin
                n_active = 1'b1;
                if (w_ft >= FTW'(TAG_COUNT)) begin
                    // Table full: drop the byte.
                    n_fill_tag = w_ft;
                end else if (w_sw && i_byte == dtt_pkg::SEMICOLON) begin
                    n_swallow = 1'b0;
                end else if (i_byte == dtt_pkg::SEMICOLON) begin
                    w_len_we   = 1'b1;
                    w_len_val  = w_fp;
                    n_fill_tag = w_ft + FTW'(1);
                    n_fill_pos = '0;
                    n_swallow  = 1'b0;
                end else begin
                    o_we      = 1'b1;
                    w_len_we  = 1'b1;
                    w_len_val = w_fp_inc;
                    if (w_fp_inc == PW'(TAG_BYTES - 1)) begin
                        n_fill_tag = w_ft + FTW'(1);
                        n_fill_pos = '0;
                        n_swallow  = 1'b1;
                    end else begin
                        n_fill_pos = w_fp_inc;
                        n_swallow  = 1'b0;
                    end
                end
            end
        end

        for (int i = 0; i < TAG_COUNT; i++) begin
            if (w_len_we && w_ft == FTW'(i)) begin
                n_tag_len[i] = w_len_val;
            end else if (w_clear) begin
                n_tag_len[i] = '0;
            end else begin
                n_tag_len[i] = r_tag_len[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_tag <= '0;
            r_fill_pos <= '0;
            r_swallow  <= 1'b0;
            r_active   <= 1'b0;
            r_tag_len  <= '0;
        end else begin
            r_fill_tag <= n_fill_tag;
            r_fill_pos <= n_fill_pos;
            r_swallow  <= n_swallow;
            r_active   <= n_active;
            r_tag_len  <= n_tag_len;
        end
    end

    assign o_waddr   = w_fp;
    assign o_wlane   = w_ft[IW-1:0];
    assign o_wdata   = i_byte;
    assign o_tag_len = r_tag_len;

endmodule

`default_nettype wire

[design/dtt_match.sv]
`default_nettype none

// Key matcher: narrows the candidate set one key position at a time against
// a row of the tag store, and reports the lowest surviving tag.
module dtt_match #(
    parameter int TAG_COUNT = 16,
    parameter int PW        = 6,
    parameter int IW        = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_clear,
    input  wire logic [7:0]                    i_key,
    input  wire logic [TAG_COUNT-1:0][7:0]     i_row,
    input  wire logic [TAG_COUNT-1:0][PW-1:0]  i_tag_len,
    output logic      [dtt_pkg::QW-1:0]        o_query_pos,
    output logic                               o_hit,
    output logic      [IW-1:0]                 o_hit_idx
);

    logic [TAG_COUNT-1:0]   r_match_set, n_match_set;
    logic [dtt_pkg::QW-1:0] r_query_pos, n_query_pos;

    always_comb begin
        n_match_set = r_match_set;
        n_query_pos = r_query_pos;
        if (i_clear) begin
            n_match_set = '1;
            n_query_pos = '0;
        end else if (i_step) begin
            for (int i = 0; i < TAG_COUNT; i++) begin
                n_match_set[i] = r_match_set[i]
                    && (r_query_pos < dtt_pkg::QW'(i_tag_len[i]))
                    && (i_row[i] == i_key);
            end
            if (r_query_pos != dtt_pkg::QPOS_MAX) begin
                n_query_pos = r_query_pos + dtt_pkg::QW'(1);
            end
        end
    end

    // Lowest set bit wins.
    always_comb begin
        o_hit     = |r_match_set;
        o_hit_idx = '0;
        for (int i = TAG_COUNT - 1; i >= 0; i--) begin
            if (r_match_set[i]) begin
                o_hit_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_set <= '1;
            r_query_pos <= '0;
        end else begin
            r_match_set <= n_match_set;
            r_query_pos <= n_query_pos;
        end
    end

    assign o_query_pos = r_query_pos;

endmodule

`default_nettype wire

[design/delimited_tag_table_lookup.sv]
// A load byte is taken while idle; a nonzero key byte goes from idle to CMP
// (tag-store row read, then compare of all tags at once).
// The terminating key byte gives its result from ONE for a miss or an empty
// value, else via READ then EMIT, which waits for ready; each value byte takes
// its own READ and EMIT, set by the single registered read port of the tag store.
// Reset (synchronous, i_rst_n low) clears tag lengths, load and query state.
`default_nettype none

module delimited_tag_table_lookup #(
    parameter int TAG_COUNT = 16,
    parameter int TAG_BYTES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtt_in_if.sink     i_in,
    dtt_out_if.source  o_out
);

    // Tag index, fill counter and byte position widths.
    localparam int IW  = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int FTW = $clog2(TAG_COUNT + 1);
    localparam int PW  = $clog2(TAG_BYTES);

    dtt_pkg::t_state r_state, n_state;

    // Query datapath registers.
    logic [7:0]             r_key, n_key;
    logic [dtt_pkg::QW-1:0] r_pos, n_pos;
    logic [PW-1:0]          r_len, n_len;
    logic [IW-1:0]          r_hit, n_hit;
    logic                   r_found, n_found;

    logic w_accept;
    logic w_load;
    logic w_step;
    logic w_clear;
    logic w_re;
    logic [PW-1:0] w_raddr;
    logic w_last;

    logic                         w_we;
    logic [PW-1:0]                w_waddr;
    logic [IW-1:0]                w_wlane;
    logic [7:0]                   w_wdata;
    logic [TAG_COUNT-1:0][PW-1:0] w_tag_len;
    logic [TAG_COUNT-1:0][7:0]    w_row;
    logic [dtt_pkg::QW-1:0]       w_query_pos;
    logic                         w_hit;
    logic [IW-1:0]                w_hit_idx;

    // Take items only while idle; the block works one item at a time.
    assign i_in.ready = (r_state == dtt_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && (i_in.op == dtt_pkg::OP_LOAD);

    dtt_loader #(
        .TAG_COUNT (TAG_COUNT),
        .TAG_BYTES (TAG_BYTES),
        .PW        (PW),
        .IW        (IW),
        .FTW       (FTW)
    ) u_loader (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_byte    (i_in.char_byte),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wlane   (w_wlane),
        .o_wdata   (w_wdata),
        .o_tag_len (w_tag_len)
    );

    dtt_tag_ram #(
        .LANES (TAG_COUNT),
        .ROWS  (TAG_BYTES),
        .AW    (PW),
        .LW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wlane (w_wlane),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rrow  (w_row)
    );

    dtt_match #(
        .TAG_COUNT (TAG_COUNT),
        .PW        (PW),
        .IW        (IW)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_clear     (w_clear),
        .i_key       (r_key),
        .i_row       (w_row),
        .i_tag_len   (w_tag_len),
        .o_query_pos (w_query_pos),
        .o_hit       (w_hit),
        .o_hit_idx   (w_hit_idx)
    );

    // Final value byte when the next position reaches the tag length.
    assign w_last = ((r_pos + dtt_pkg::QW'(1)) == dtt_pkg::QW'(r_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_pos   <= n_pos;
        r_len   <= n_len;
        r_hit   <= n_hit;
        r_found <= n_found;
    end

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_pos   = r_pos;
        n_len   = r_len;
        n_hit   = r_hit;
        n_found = r_found;
        w_step  = 1'b0;
        w_clear = 1'b0;
        w_re    = 1'b0;
        w_raddr = w_query_pos[PW-1:0];

        o_out.valid      = 1'b0;
        o_out.found      = 1'b0;
        o_out.tag_index  = '0;
        o_out.value_byte = '0;
        o_out.byte_valid = 1'b0;
        o_out.last       = 1'b0;

        case (r_state)
            dtt_pkg::ST_IDLE: begin
                // Keep the row at the current key position coming.
                w_re    = 1'b1;
                w_raddr = w_query_pos[PW-1:0];
                if (w_accept && i_in.op == dtt_pkg::OP_QUERY) begin
                    if (i_in.char_byte != dtt_pkg::NUL_BYTE) begin
                        n_key   = i_in.char_byte;
                        n_state = dtt_pkg::ST_CMP;
                    end else begin
                        // End of key: latch the hit and restart the matcher.
                        w_clear = 1'b1;
                        n_found = w_hit;
                        n_hit   = w_hit_idx;
                        n_len   = w_tag_len[w_hit_idx];
                        n_pos   = w_query_pos;
                        if (!w_hit ||
                            w_query_pos >= dtt_pkg::QW'(w_tag_len[w_hit_idx])) begin
                            n_state = dtt_pkg::ST_ONE;
                        end else begin
                            n_state = dtt_pkg::ST_READ;
                        end
                    end
                end
            end
            dtt_pkg::ST_CMP: begin
                w_step  = 1'b1;
                n_state = dtt_pkg::ST_IDLE;
            end
            dtt_pkg::ST_ONE: begin
                // Miss, or hit with nothing after the key.
                o_out.valid     = 1'b1;
                o_out.found     = r_found;
                o_out.tag_index = r_found ? 4'(r_hit) : 4'd0;
                o_out.last      = 1'b1;
                if (o_out.ready) begin
                    n_state = dtt_pkg::ST_IDLE;
                end
            end
            dtt_pkg::ST_READ: begin
                w_re    = 1'b1;
                w_raddr = r_pos[PW-1:0];
                n_state = dtt_pkg::ST_EMIT;
            end
            dtt_pkg::ST_EMIT: begin
                // Hold the read row until the item is taken.
                o_out.valid      = 1'b1;
                o_out.found      = 1'b1;
                o_out.tag_index  = 4'(r_hit);
                o_out.value_byte = w_row[r_hit];
                o_out.byte_valid = 1'b1;
                o_out.last       = w_last;
                if (o_out.ready) begin
                    if (w_last) begin
                        n_state = dtt_pkg::ST_IDLE;
                    end else begin
                        n_pos   = r_pos + dtt_pkg::QW'(1);
                        n_state = dtt_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = dtt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/dtt_checker.sv]
`default_nettype none

module dtt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_found,
    input wire logic [3:0] i_out_tag_index,
    input wire logic [7:0] i_out_value_byte,
    input wire logic       i_out_byte_valid,
    input wire logic       i_out_last
);

    // Results and input acceptance never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_in_valid && i_in_ready))
        else $error("result offered while input is accepted");

    // A miss is a single all-zero item marked last.
    a_miss_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |->
            (i_out_last && !i_out_byte_valid && i_out_tag_index == 4'd0
             && i_out_value_byte == 8'd0))
        else $error("malformed miss result");

    // An item without a value byte ends the run.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_byte_valid) |-> i_out_last)
        else $error("empty result not marked last");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value_byte) && $stable(i_out_tag_index)
             && $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind delimited_tag_table_lookup dtt_checker u_dtt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_found      (o_out.found),
    .i_out_tag_index  (o_out.tag_index),
    .i_out_value_byte (o_out.value_byte),
    .i_out_byte_valid (o_out.byte_valid),
    .i_out_last       (o_out.last)
);

`default_nettype wire

[verif/tag_lookup_check.sv]
module tag_lookup_check #(
    parameter int TAG_COUNT = 16,
    parameter int TAG_BYTES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtt_in_if         i_in,
    dtt_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_W       = $clog2(TAG_COUNT + 1);
    localparam int POS_W       = (TAG_BYTES > 2) ? $clog2(TAG_BYTES) : 1;
    localparam int LEN_W       = 7;

    typedef struct packed {
        logic       found;
        logic [3:0] tag_index;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       last;
    } t_answer;

    // Mirror of the table and of the load and query state.
    logic [7:0]              tag_store  [TAG_COUNT][TAG_BYTES];
    logic [LEN_W-1:0]        tag_length [TAG_COUNT];
    logic [TAG_W-1:0]        fill_tag;
    logic [POS_W-1:0]        fill_pos;
    logic                    swallow_pending;
    logic                    load_active;
    logic [dtt_pkg::QW-1:0]  query_pos;
    logic [TAG_COUNT-1:0]    match_set;

    t_answer expected_answers [$];
    int      answers_seen = 0;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t ns lookup check: %s", $time, msg);
    endtask

    function automatic string answer_text(input t_answer a);
        return $sformatf("found=%b tag=%0d value=%h byte_valid=%b last=%b",
                         a.found, a.tag_index, a.value_byte, a.byte_valid, a.last);
    endfunction

    task automatic load_char(input logic [7:0] ch);
        // First byte of a new load: forget every tag.
        if (!load_active) begin
            foreach (tag_length[i]) tag_length[i] = '0;
            fill_tag        = '0;
            fill_pos        = '0;
            swallow_pending = 1'b0;
            load_active     = 1'b1;
        end
        if (ch == dtt_pkg::NUL_BYTE) begin
            load_active = 1'b0;
            return;
        end
        if (fill_tag >= TAG_COUNT) return;
        if (swallow_pending) begin
            swallow_pending = 1'b0;
            if (ch == dtt_pkg::SEMICOLON) return;
        end
        if (ch == dtt_pkg::SEMICOLON) begin
            tag_length[fill_tag] = LEN_W'(fill_pos);
            fill_tag++;
            fill_pos = '0;
            return;
        end
        tag_store[fill_tag][fill_pos] = ch;
        fill_pos++;
        tag_length[fill_tag] = LEN_W'(fill_pos);
        if (fill_pos >= TAG_BYTES - 1) begin
            fill_tag++;
            fill_pos        = '0;
            swallow_pending = 1'b1;
        end
    endtask

    task automatic query_char(input logic [7:0] ch);
        int hit;
        if (ch != dtt_pkg::NUL_BYTE) begin
            for (int i = 0; i < TAG_COUNT; i++) begin
                if (match_set[i] &&
                    (query_pos >= tag_length[i] ||
                     tag_store[i][query_pos[POS_W-1:0]] != ch))
                    match_set[i] = 1'b0;
            end
            if (query_pos < dtt_pkg::QPOS_MAX) query_pos++;
            return;
        end
        hit = -1;
        for (int i = TAG_COUNT - 1; i >= 0; i--)
            if (match_set[i]) hit = i;
        if (hit < 0) begin
            expected_answers.push_back('{found: 1'b0, tag_index: 4'd0, value_byte: 8'h00,
                                         byte_valid: 1'b0, last: 1'b1});
        end else if (query_pos >= tag_length[hit]) begin
            expected_answers.push_back('{found: 1'b1, tag_index: 4'(hit), value_byte: 8'h00,
                                         byte_valid: 1'b0, last: 1'b1});
        end else begin
            for (int p = int'(query_pos); p < int'(tag_length[hit]); p++)
                expected_answers.push_back('{found: 1'b1, tag_index: 4'(hit),
                                             value_byte: tag_store[hit][p], byte_valid: 1'b1,
                                             last: (p + 1 == int'(tag_length[hit]))});
        end
        query_pos = '0;
        match_set = '1;
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            foreach (tag_length[i]) tag_length[i] = '0;
            fill_tag        = '0;
            fill_pos        = '0;
            swallow_pending = 1'b0;
            load_active     = 1'b0;
            query_pos       = '0;
            match_set       = '1;
            expected_answers.delete();
        end else begin
            // An item accepted at this edge cannot answer at the same edge, so
            // compare outputs first and then advance the predictor.
            if (i_out.valid && i_out.ready) begin
                got = '{found: i_out.found, tag_index: i_out.tag_index,
                        value_byte: i_out.value_byte, byte_valid: i_out.byte_valid,
                        last: i_out.last};
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result %0d not expected: %s",
                                              answers_seen, answer_text(got)));
                end else begin
                    want = expected_answers.pop_front();
                    if (got.found !== want.found || got.tag_index !== want.tag_index ||
                        got.value_byte !== want.value_byte ||
                        got.byte_valid !== want.byte_valid || got.last !== want.last)
                        report_mismatch($sformatf("result %0d got %s, want %s", answers_seen,
                                                  answer_text(got), answer_text(want)));
                end
                answers_seen++;
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == dtt_pkg::OP_LOAD) load_char(i_in.char_byte);
                else query_char(i_in.char_byte);
            end
        end
        o_pending = expected_answers.size();
    end

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TAG_COUNT      = 16;
    localparam int  TAG_BYTES      = 64;
    localparam int  RANDOM_ITEMS   = 360;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 20;
    localparam int  SEND_IDLE_PCT  = 59;
    localparam int  RECV_STALL_PCT = 59;
    localparam int  BOTH_IDLE_PCT  = 23;
    localparam int  OVERLONG_KEY   = 130;
    localparam int  RESET_CYCLES   = 10;
    localparam int  TIMEOUT_NS     = 20_000_000;

    // Which side inserts bubbles in the current stretch of the run.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    int    fail_count;
    int    pending;
    t_idle idle_mode   = IDLE_NONE;
    bit    hold_req    = 1'b0;
    bit    hold_done   = 1'b0;
    int    sent_items  = 0;

    // Tags as the generator meant them; used only to pick keys that hit.
    logic [7:0] known_tag [TAG_COUNT][$];
    int         known_count = 0;

    dtt_in_if  in_if ();
    dtt_out_if out_if ();

    delimited_tag_table_lookup #(
        .TAG_COUNT(TAG_COUNT),
        .TAG_BYTES(TAG_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    tag_lookup_check #(
        .TAG_COUNT(TAG_COUNT),
        .TAG_BYTES(TAG_BYTES)
    ) u_lookup_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns period: low half, then high half.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly a small alphabet so that keys collide on prefixes; the rest
    // exercises printable text, the upper half of the byte range and anything
    // nonzero (an odd semicolon inside a tag breaks it, which is wanted too).
    function automatic logic [7:0] pick_char();
        int dice;
        dice = $urandom_range(99);
        if (dice < 75) return 8'(8'h61 + $urandom_range(3));
        if (dice < 90) return 8'($urandom_range(8'h41, 8'h7A));
        if (dice < 97) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(1, 255));
    endfunction

    // Offer one item at a falling edge and hold it until accepted. Bubbles come
    // before the item, so valid stays high between back-to-back items and each
    // falling edge carries at most one assignment to it.
    task automatic send_byte(input dtt_pkg::t_op op, input logic [7:0] ch);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < SEND_IDLE_PCT) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < BOTH_IDLE_PCT)) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.char_byte <= ch;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
    endtask

    // Query with a prefix of a tag the generator loaded; now and then spoil it
    // with one extra byte so the lookup usually misses.
    task automatic query_known();
        int slot;
        int key_len;
        if (known_count == 0) begin
            send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
            return;
        end
        slot    = $urandom_range(known_count - 1);
        key_len = $urandom_range(known_tag[slot].size());
        for (int k = 0; k < key_len; k++) send_byte(dtt_pkg::OP_QUERY, known_tag[slot][k]);
        if ($urandom_range(9) == 0) send_byte(dtt_pkg::OP_QUERY, pick_char());
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
    endtask

    // Load a semicolon-separated string. Long tags land on or around the full
    // length; a full first tag is always followed by a semicolon so that the
    // swallowed separator is hit. Other full tags sometimes run straight into
    // the next tag. With mixing on, queries cut into the load between tags.
    task automatic load_string(input int n_tags, input int long_pct,
                               input bit first_full, input bit mix_queries);
        int         len;
        bit         skip_sep;
        logic [7:0] ch;
        known_count = 0;
        for (int t = 0; t < n_tags; t++) begin
            if (first_full && t == 0) len = TAG_BYTES - 1;
            else if ($urandom_range(99) < long_pct)
                len = $urandom_range(1) ? TAG_BYTES - 1
                                        : $urandom_range(TAG_BYTES - 5, TAG_BYTES + 5);
            else len = $urandom_range(0, 6);
            if (t < TAG_COUNT) known_tag[t].delete();
            for (int k = 0; k < len; k++) begin
                ch = pick_char();
                send_byte(dtt_pkg::OP_LOAD, ch);
                if (t < TAG_COUNT && k < TAG_BYTES - 1) known_tag[t].push_back(ch);
            end
            if (t < TAG_COUNT) known_count = t + 1;
            skip_sep = (len == TAG_BYTES - 1) && !(first_full && t == 0) &&
                       $urandom_range(1);
            if (!skip_sep && (t < n_tags - 1 || $urandom_range(1)))
                send_byte(dtt_pkg::OP_LOAD, dtt_pkg::SEMICOLON);
            if (mix_queries && $urandom_range(99) < 15) query_known();
        end
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::NUL_BYTE);
    endtask

    // Receiver: ready changes at falling edges. A hold-off request keeps it
    // low for a long counted stretch while the sender keeps offering items.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (idle_mode == IDLE_RECV) begin
                out_if.ready <= ($urandom_range(99) >= RECV_STALL_PCT);
            end else if (idle_mode == IDLE_BOTH) begin
                out_if.ready <= ($urandom_range(99) >= BOTH_IDLE_PCT);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int random_start;
        int random_done;
        int dice;
        in_if.valid     = 1'b0;
        in_if.op        = dtt_pkg::OP_LOAD;
        in_if.char_byte = dtt_pkg::NUL_BYTE;
        i_rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty key on the empty table after reset: tag 0 matches with no bytes.
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        // Zero byte as the first load byte: every tag stays empty.
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::NUL_BYTE);
        // Table "ab", one high byte, an empty tag, "x".
        send_byte(dtt_pkg::OP_LOAD, "a");
        send_byte(dtt_pkg::OP_LOAD, "b");
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::SEMICOLON);
        send_byte(dtt_pkg::OP_LOAD, 8'hC5);
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::SEMICOLON);
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::SEMICOLON);
        send_byte(dtt_pkg::OP_LOAD, "x");
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::NUL_BYTE);
        // Empty key streams the whole of tag 0.
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        // Key equal to a whole tag: found with an empty value.
        send_byte(dtt_pkg::OP_QUERY, 8'hC5);
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        // Proper prefix: stream the rest.
        send_byte(dtt_pkg::OP_QUERY, "a");
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        // Miss.
        send_byte(dtt_pkg::OP_QUERY, "q");
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        // Query in the middle of a load sees the new, partial table.
        send_byte(dtt_pkg::OP_LOAD, 8'hFF);
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        send_byte(dtt_pkg::OP_LOAD, "z");
        send_byte(dtt_pkg::OP_QUERY, 8'hFF);
        send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
        send_byte(dtt_pkg::OP_LOAD, dtt_pkg::NUL_BYTE);

        random_start = sent_items;
        random_done  = 0;
        for (int k = 0; random_done < RANDOM_ITEMS; k++) begin
            case (random_done * 4 / RANDOM_ITEMS)
                0:       idle_mode = IDLE_NONE;
                1:       idle_mode = IDLE_SEND;
                2:       idle_mode = IDLE_RECV;
                default: idle_mode = IDLE_BOTH;
            endcase
            if (k == 2) begin
                // Long receiver hold-off with a burst of queries behind it.
                hold_req = 1'b1;
                repeat (4) query_known();
            end else if (k == 6) begin
                // Full first tag followed by a swallowed semicolon.
                load_string(2, 0, 1'b1, 1'b0);
            end else if (k == 12) begin
                // Over-long key: the position count saturates and nothing matches.
                repeat (OVERLONG_KEY) send_byte(dtt_pkg::OP_QUERY, pick_char());
                send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
            end else if (k == 18) begin
                // More tags than the table holds: the tail is dropped.
                load_string(TAG_COUNT + 2, 0, 1'b0, 1'b0);
            end else begin
                dice = $urandom_range(99);
                if (dice < 20) begin
                    load_string($urandom_range(1, 8), 5, 1'b0, 1'b1);
                end else if (dice < 65) begin
                    query_known();
                end else if (dice < 80) begin
                    repeat ($urandom_range(0, 3)) send_byte(dtt_pkg::OP_QUERY, pick_char());
                    send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
                end else if (dice < 90) begin
                    // Raw load bytes, zeros and semicolons included.
                    repeat ($urandom_range(0, 8))
                        send_byte(dtt_pkg::OP_LOAD, 8'($urandom_range(255)));
                    send_byte(dtt_pkg::OP_LOAD, dtt_pkg::NUL_BYTE);
                end else begin
                    repeat ($urandom_range(0, 5))
                        send_byte(dtt_pkg::OP_QUERY, 8'($urandom_range(1, 255)));
                    send_byte(dtt_pkg::OP_QUERY, dtt_pkg::NUL_BYTE);
                end
            end
            random_done = sent_items - random_start;
        end

        // Drop valid, let the receiver run freely and drain what is owed.
        in_if.valid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
